// ===== hdl/corner_point_rectangle_packer_core_defines.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the corner point packer
// ----------------------------------------------------------------------------
`ifndef CORNER_POINT_RECTANGLE_PACKER_CORE_DEFINES_SVH
`define CORNER_POINT_RECTANGLE_PACKER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define CPRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CPRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cprp_pkg.sv =====
// ----------------------------------------------------------------------------
// cprp_pkg
// shared types, sizes and helpers of the corner point rectangle packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cprp_pkg;

  localparam int MAX_RECTS   = 256;
  localparam int MAX_CORNERS = 257;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
  localparam int CIDX_W      = $clog2(MAX_CORNERS);
  localparam int RIDX_W      = $clog2(MAX_RECTS);
  localparam int ADDR_W      = 4;

  localparam logic [DIM_W-1:0] INIT_SIDE_RST  = 13'd128;
  localparam logic [DIM_W-1:0] SIDE_LIMIT_RST = 13'd4096;

  // register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_INIT_W = 2'd0;
  localparam logic [1:0] REG_INIT_H = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  localparam logic FUNC_PLACE   = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [1:0] {
    STAT_PLACED  = 2'd0,
    STAT_RESTART = 2'd1,
    STAT_LIMIT   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_CRD,
    ST_CCHK,
    ST_RSCAN,
    ST_NEXT,
    ST_RM,
    ST_RM_RD,
    ST_RM_WR,
    ST_IN_START,
    ST_IN_RD,
    ST_IN_WR,
    ST_IN_W0,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
  } corner_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } rect_t;

  // overlap on one axis between a placed span and a candidate span
  function automatic logic axis_hit(input logic [DIM_W-1:0] pc, input logic [DIM_W-1:0] cc,
                                    input logic [DIM_W-1:0] cand_len,
                                    input logic [DIM_W-1:0] placed_len);
    logic res;
    if (pc > cc) begin
      res = (pc - cc) < cand_len;
    end else begin
      res = (cc - pc) < placed_len;
    end
    return res;
  endfunction

  // sort order of the corner list: y first, then x
  function automatic logic corner_before(input corner_t a, input corner_t b);
    return (a.y < b.y) || ((a.y == b.y) && (a.x < b.x));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cprp_item_if.sv =====
// ----------------------------------------------------------------------------
// cprp_item_if
// input channel: one rectangle request or restart per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cprp_item_if;
  import cprp_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;

  modport source (output valid, func, rect_width, rect_height, input ready);
  modport sink (input valid, func, rect_width, rect_height, output ready);
endinterface

`default_nettype wire

// ===== hdl/cprp_result_if.sv =====
// ----------------------------------------------------------------------------
// cprp_result_if
// output channel: one placement result per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cprp_result_if;
  import cprp_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [DIM_W-1:0] atlas_width;
  logic [DIM_W-1:0] atlas_height;

  modport source (output valid, status, pos_x, pos_y, atlas_width, atlas_height, input ready);
  modport sink (input valid, status, pos_x, pos_y, atlas_width, atlas_height, output ready);
endinterface

`default_nettype wire

// ===== hdl/corner_point_rectangle_packer_core.sv =====
// ----------------------------------------------------------------------------
// corner_point_rectangle_packer_core
// greedy corner point packer of rectangles into a growing atlas
// ----------------------------------------------------------------------------
// usage:
//   item beats carry func (place or restart) and a rectangle size; result
//   beats carry status, position and the atlas size after the item.
//   exactly one result beat comes for each item beat, in order.
//   registers initial_width, initial_height, side_limit sit on the apb port
//   at byte addresses 0, 4, 8; write them only while the block is idle.
//   a restart or a full table gives its result without a corner scan. a
//   placement tries the corners in list order and, for each corner in
//   bounds, scans the placed rectangles for overlap; on a fit it removes
//   the used corner from the list and inserts two new corners in sort
//   order. the whole scan repeats after each atlas enlargement. the
//   corner memory and the rectangle memory each have a single read port.
//   one item is worked on at a time; the next item is taken while the last
//   result still waits in the output register.
//   reset: one cycle after rst falls the corner list holds the corner 0,0
//   and the block takes items. a stalled receiver holds the result; a
//   finished item then waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "corner_point_rectangle_packer_core_defines.svh"

module corner_point_rectangle_packer_core
  import cprp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  cprp_item_if.sink              item,
  cprp_result_if.source          result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // configuration registers
  logic [DIM_W-1:0] initial_width;
  logic [DIM_W-1:0] initial_height;
  logic [DIM_W-1:0] side_limit;

  // control and working registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  ccount, ccount_next;
  logic [CNT_W-1:0]  pcount, pcount_next;
  logic [DIM_W-1:0]  cur_w, cur_w_next;
  logic [DIM_W-1:0]  cur_h, cur_h_next;
  logic [DIM_W-1:0]  aw, aw_next;
  logic [DIM_W-1:0]  ah, ah_next;
  logic [DIM_W-1:0]  req_w, req_w_next;
  logic [DIM_W-1:0]  req_h, req_h_next;
  logic [DIM_W-1:0]  cx, cx_next;
  logic [DIM_W-1:0]  cy, cy_next;
  logic [CIDX_W-1:0] ci, ci_next;
  logic [CNT_W-1:0]  ri, ri_next;
  logic              rv, rv_next;
  logic [CIDX_W-1:0] k, k_next;
  corner_t           ins, ins_next;
  logic              phase, phase_next;
  status_t           ostat, ostat_next;
  logic [POS_W-1:0]  opx, opx_next;
  logic [POS_W-1:0]  opy, opy_next;

  // output register
  logic              oval;
  status_t           o_status;
  logic [POS_W-1:0]  o_px;
  logic [POS_W-1:0]  o_py;
  logic [DIM_W-1:0]  o_w;
  logic [DIM_W-1:0]  o_h;

  // memories
  corner_t           cmem [MAX_CORNERS];
  rect_t             rmem [MAX_RECTS];
  logic              cwe;
  logic [CIDX_W-1:0] cwaddr;
  corner_t           cwdata;
  logic [CIDX_W-1:0] craddr;
  corner_t           crdata;
  logic              rwe;
  logic [RIDX_W-1:0] rwaddr;
  rect_t             rwdata;
  logic [RIDX_W-1:0] rraddr;
  rect_t             rrdata;

  // shared conditions
  logic              acc;
  logic              cfg_wr;
  logic              full;
  logic              in_bounds;
  logic              last_corner;
  logic              square;
  logic [DIM_W-1:0]  grow_side;
  logic              grow_ok;
  logic              rq;
  logic              hit;
  logic              fit;
  logic              ins_before;
  logic              out_load;

  assign pready = 1'b1;
  assign acc    = item.valid && item.ready;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_width  <= INIT_SIDE_RST;
      initial_height <= INIT_SIDE_RST;
      side_limit     <= SIDE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INIT_W: initial_width  <= pwdata[DIM_W-1:0];
        REG_INIT_H: initial_height <= pwdata[DIM_W-1:0];
        REG_LIMIT:  side_limit     <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_INIT_W: prdata = {{(32-DIM_W){1'b0}}, initial_width};
      REG_INIT_H: prdata = {{(32-DIM_W){1'b0}}, initial_height};
      REG_LIMIT:  prdata = {{(32-DIM_W){1'b0}}, side_limit};
      default:    prdata = 32'd0;
    endcase
  end

  // corner memory
  always_ff @(posedge clk) begin
    if (cwe) begin
      cmem[cwaddr] <= cwdata;
    end
    crdata <= cmem[craddr];
  end

  // placed rectangle memory
  always_ff @(posedge clk) begin
    if (rwe) begin
      rmem[rwaddr] <= rwdata;
    end
    rrdata <= rmem[rraddr];
  end

  // conditions on the current corner and rectangle
  assign full        = (pcount >= CNT_W'(MAX_RECTS)) || (ccount >= CNT_W'(MAX_CORNERS));
  assign in_bounds   = ({1'b0, crdata.x} + {1'b0, req_w} <= {1'b0, aw})
                    && ({1'b0, crdata.y} + {1'b0, req_h} <= {1'b0, ah});
  assign last_corner = ({1'b0, ci} + 1'b1) == {1'b0, ccount};
  assign square      = (aw == ah);
  assign grow_side   = square ? ah : aw;
  assign grow_ok     = (grow_side != '0) && ({grow_side, 1'b0} <= {1'b0, side_limit});
  assign rq          = ri < pcount;
  assign hit         = rv && axis_hit(rrdata.x, cx, req_w, rrdata.w)
                          && axis_hit(rrdata.y, cy, req_h, rrdata.h);
  assign fit         = !hit && !rq && !rv;
  assign ins_before  = corner_before(ins, crdata);
  assign out_load    = (state == ST_OUT) && (!oval || result.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          if (item.func == FUNC_RESTART) begin
            state_next = ST_CLR;
          end else if (full) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_CRD;
          end
        end
      end
      ST_CLR:  state_next = ST_OUT;
      ST_CRD:  state_next = ST_CCHK;
      ST_CCHK: state_next = in_bounds ? ST_RSCAN : ST_NEXT;
      ST_RSCAN: begin
        if (hit) begin
          state_next = ST_NEXT;
        end else if (fit) begin
          state_next = ST_RM;
        end
      end
      ST_NEXT: begin
        if (!last_corner || grow_ok) begin
          state_next = ST_CRD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_RM:    state_next = (({1'b0, k} + 1'b1) == {1'b0, ccount}) ? ST_IN_START : ST_RM_RD;
      ST_RM_RD: state_next = ST_RM_WR;
      ST_RM_WR: state_next = ST_RM;
      ST_IN_START: state_next = (ccount == '0) ? ST_IN_W0 : ST_IN_RD;
      ST_IN_RD: state_next = ST_IN_WR;
      ST_IN_WR: begin
        if (ins_before) begin
          state_next = (k == '0) ? ST_IN_W0 : ST_IN_RD;
        end else begin
          state_next = phase ? ST_OUT : ST_IN_START;
        end
      end
      ST_IN_W0: state_next = phase ? ST_OUT : ST_IN_START;
      ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ccount_next = ccount;
    pcount_next = pcount;
    cur_w_next  = cur_w;
    cur_h_next  = cur_h;
    aw_next     = aw;
    ah_next     = ah;
    req_w_next  = req_w;
    req_h_next  = req_h;
    cx_next     = cx;
    cy_next     = cy;
    ci_next     = ci;
    ri_next     = ri;
    rv_next     = 1'b0;
    k_next      = k;
    ins_next    = ins;
    phase_next  = phase;
    ostat_next  = ostat;
    opx_next    = opx;
    opy_next    = opy;
    cwe         = 1'b0;
    cwaddr      = k;
    cwdata      = ins;
    craddr      = ci;
    rwe         = 1'b0;
    rwaddr      = pcount[RIDX_W-1:0];
    rwdata      = '{x: cx, y: cy, w: req_w, h: req_h};
    rraddr      = ri[RIDX_W-1:0];
    item.ready  = (state == ST_IDLE);
    case (state)
      ST_INIT: begin
        cwe    = 1'b1;
        cwaddr = '0;
        cwdata = '0;
      end
      ST_IDLE: begin
        if (acc) begin
          req_w_next = item.rect_width;
          req_h_next = item.rect_height;
          aw_next    = cur_w;
          ah_next    = cur_h;
          ci_next    = '0;
          opx_next   = '0;
          opy_next   = '0;
          if (item.func == FUNC_RESTART) begin
            ostat_next  = STAT_RESTART;
            ccount_next = CNT_W'(1);
            pcount_next = '0;
            cur_w_next  = initial_width;
            cur_h_next  = initial_height;
          end else if (full) begin
            ostat_next = STAT_FULL;
          end
        end
      end
      ST_CLR: begin
        cwe    = 1'b1;
        cwaddr = '0;
        cwdata = '0;
      end
      ST_CCHK: begin
        cx_next = crdata.x;
        cy_next = crdata.y;
        ri_next = '0;
      end
      ST_RSCAN: begin
        if (fit) begin
          // place here and start the corner list update
          rwe         = 1'b1;
          pcount_next = pcount + 1'b1;
          cur_w_next  = aw;
          cur_h_next  = ah;
          ostat_next  = STAT_PLACED;
          opx_next    = cx[POS_W-1:0];
          opy_next    = cy[POS_W-1:0];
          k_next      = ci;
        end else if (!hit) begin
          rv_next = rq;
          if (rq) begin
            ri_next = ri + 1'b1;
          end
        end
      end
      ST_NEXT: begin
        if (!last_corner) begin
          ci_next = ci + 1'b1;
        end else if (grow_ok) begin
          ci_next = '0;
          if (square) begin
            ah_next = {ah[DIM_W-2:0], 1'b0};
          end else begin
            aw_next = {aw[DIM_W-2:0], 1'b0};
          end
        end else begin
          ostat_next = STAT_LIMIT;
        end
      end
      ST_RM: begin
        if (({1'b0, k} + 1'b1) == {1'b0, ccount}) begin
          ccount_next = ccount - 1'b1;
          ins_next    = '{x: cx + req_w, y: cy};
          phase_next  = 1'b0;
        end
      end
      ST_RM_RD: craddr = k + 1'b1;
      ST_RM_WR: begin
        cwe    = 1'b1;
        cwaddr = k;
        cwdata = crdata;
        k_next = k + 1'b1;
      end
      ST_IN_START: k_next = CIDX_W'(ccount - 1'b1);
      ST_IN_RD: craddr = k;
      ST_IN_WR: begin
        cwe    = 1'b1;
        cwaddr = k + 1'b1;
        if (ins_before) begin
          cwdata = crdata;
          if (k != '0) begin
            k_next = k - 1'b1;
          end
        end else begin
          cwdata      = ins;
          ccount_next = ccount + 1'b1;
          phase_next  = 1'b1;
          ins_next    = '{x: cx, y: cy + req_h};
        end
      end
      ST_IN_W0: begin
        cwe         = 1'b1;
        cwaddr      = '0;
        cwdata      = ins;
        ccount_next = ccount + 1'b1;
        phase_next  = 1'b1;
        ins_next    = '{x: cx, y: cy + req_h};
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      ccount <= CNT_W'(1);
      pcount <= '0;
      cur_w  <= INIT_SIDE_RST;
      cur_h  <= INIT_SIDE_RST;
      rv     <= 1'b0;
    end else begin
      state  <= state_next;
      ccount <= ccount_next;
      pcount <= pcount_next;
      cur_w  <= cur_w_next;
      cur_h  <= cur_h_next;
      rv     <= rv_next;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    aw    <= aw_next;
    ah    <= ah_next;
    req_w <= req_w_next;
    req_h <= req_h_next;
    cx    <= cx_next;
    cy    <= cy_next;
    ci    <= ci_next;
    ri    <= ri_next;
    k     <= k_next;
    ins   <= ins_next;
    phase <= phase_next;
    ostat <= ostat_next;
    opx   <= opx_next;
    opy   <= opy_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else if (out_load) begin
      oval <= 1'b1;
    end else if (result.ready) begin
      oval <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status <= ostat;
      o_px     <= opx;
      o_py     <= opy;
      o_w      <= cur_w;
      o_h      <= cur_h;
    end
  end

  assign result.valid        = oval;
  assign result.status       = o_status;
  assign result.pos_x        = o_px;
  assign result.pos_y        = o_py;
  assign result.atlas_width  = o_w;
  assign result.atlas_height = o_h;

  // checks
  `CPRP_ASSERT_NOW(a_rect_wr_room, clk, rst, rwe, pcount < CNT_W'(MAX_RECTS), "rect table overrun")
  `CPRP_ASSERT_NOW(a_scan_in_range, clk, rst, (state == ST_RSCAN) && rv, ri <= pcount, "scan past placed count")
  `CPRP_ASSERT_NOW(a_placed_counts, clk, rst, (state == ST_OUT) && (ostat == STAT_PLACED), (pcount != '0) && (ccount >= CNT_W'(2)), "placed without list update")
  `CPRP_ASSERT_NEXT(a_fit_starts_update, clk, rst, (state == ST_RSCAN) && fit, state == ST_RM, "fit did not start corner update")

endmodule

`default_nettype wire
